// ===== hdl/spdg_pkg.sv =====
// Package: shared constants and types for the dense-graph shortest path block.
package spdg_pkg;
   localparam int MaxNodes = 16;
   localparam int NodeW = $clog2(MaxNodes);
   localparam int CntW = NodeW + 1;
   localparam int WeightW = 14;
   localparam int DistW = 18;
   localparam logic [DistW-1:0] InfDist = DistW'(9999);
   localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
   localparam logic CmdWrite = 1'b0;
   localparam logic CmdRun = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_SCAN, ST_RELAX, ST_EMIT
   } state_type;

   // control broadcast from the sequencer into the cell chain
   typedef struct packed {
      logic              init;     // load distance from start row
      logic              relax;    // relax against selected node
      logic              shift;    // rotate chain by one cell
      logic [NodeW-1:0]  start;
      logic [NodeW-1:0]  sel;
      logic [DistW-1:0]  best;
   } cell_ctrl_type;
endpackage

// ===== hdl/spdg_cell.sv =====
// Cell: holds one node's distance, predecessor and visited flag, rotates through the chain.
module spdg_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  spdg_pkg::cell_ctrl_type     ctrl,
   input  logic [spdg_pkg::WeightW-1:0] weight,
   input  logic [spdg_pkg::NodeW-1:0]  prev_id,
   input  logic [spdg_pkg::DistW-1:0]  prev_dist,
   input  logic [spdg_pkg::NodeW-1:0]  prev_pred,
   input  logic                        prev_vis,
   output logic [spdg_pkg::NodeW-1:0]  id,
   output logic [spdg_pkg::DistW-1:0]  node_dist,
   output logic [spdg_pkg::NodeW-1:0]  pred,
   output logic                        vis
);
   import spdg_pkg::*;
   logic [NodeW-1:0] id_ff, pred_ff;
   logic [DistW-1:0] dist_ff;
   logic             vis_ff;
   logic [DistW:0]   sum;
   logic [DistW-1:0] cand;

   assign sum  = {1'b0, ctrl.best} + (DistW+1)'(weight);
   assign cand = sum[DistW] ? DistMax : sum[DistW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vis_ff <= 1'b0;
      end else if (ctrl.shift) begin
         id_ff <= prev_id;
         if (ctrl.init) begin
            dist_ff <= (prev_id == ctrl.start) ? '0 :
                       (weight == '0) ? InfDist : DistW'(weight);
            pred_ff <= ctrl.start;
            vis_ff  <= (prev_id == ctrl.start);
         end else if (ctrl.relax) begin
            vis_ff <= prev_vis | (prev_id == ctrl.sel);
            if (!prev_vis && prev_id != ctrl.sel && weight != '0 && cand < prev_dist) begin
               dist_ff <= cand;
               pred_ff <= ctrl.sel;
            end else begin
               dist_ff <= prev_dist;
               pred_ff <= prev_pred;
            end
         end else begin
            dist_ff <= prev_dist;
            pred_ff <= prev_pred;
            vis_ff  <= prev_vis;
         end
      end
   end
   assign id = id_ff; assign node_dist = dist_ff; assign pred = pred_ff; assign vis = vis_ff;
endmodule

// ===== hdl/spdg_chain.sv =====
// Chain: ring of node cells; the head cell sees the weight row entry and the selection logic.
module spdg_chain (
   input  logic                         clock,
   input  logic                         reset,
   input  spdg_pkg::cell_ctrl_type      ctrl,
   input  logic [spdg_pkg::WeightW-1:0] weight,
   input  logic                         seed,
   input  logic [spdg_pkg::NodeW-1:0]   seed_id,
   output logic [spdg_pkg::NodeW-1:0]   tail_id,
   output logic [spdg_pkg::DistW-1:0]   tail_dist,
   output logic [spdg_pkg::NodeW-1:0]   tail_pred,
   output logic                         tail_vis
);
   import spdg_pkg::*;
   logic [NodeW-1:0] id_w [MaxNodes];
   logic [DistW-1:0] dist_w [MaxNodes];
   logic [NodeW-1:0] pred_w [MaxNodes];
   logic             vis_w [MaxNodes];
   logic [NodeW-1:0] head_id;

   // only the head cell updates; others just rotate
   assign head_id = seed ? seed_id : id_w[MaxNodes-1];

   for (genvar g = 0; g < MaxNodes; g++) begin : g_cell
      cell_ctrl_type c;
      always_comb begin
         c = ctrl;
         if (g != 0) begin
            c.init = 1'b0;
            c.relax = 1'b0;
         end
      end
      spdg_cell u_cell (
         .clock, .reset, .ctrl(c), .weight,
         .prev_id  ((g == 0) ? head_id : id_w[(g+MaxNodes-1)%MaxNodes]),
         .prev_dist(dist_w[(g+MaxNodes-1)%MaxNodes]),
         .prev_pred(pred_w[(g+MaxNodes-1)%MaxNodes]),
         .prev_vis (vis_w[(g+MaxNodes-1)%MaxNodes]),
         .id(id_w[g]), .node_dist(dist_w[g]), .pred(pred_w[g]), .vis(vis_w[g])
      );
   end
   assign tail_id = id_w[MaxNodes-1];
   assign tail_dist = dist_w[MaxNodes-1];
   assign tail_pred = pred_w[MaxNodes-1];
   assign tail_vis = vis_w[MaxNodes-1];
endmodule

// ===== hdl/shortest_path_dense_graph_top.sv =====
// Top level: edge-weight store, run sequencer and cell chain for single-source shortest paths.
// Usage:
//  - req_ channel: cmd 0 writes edge_weight at (row_node, col_node) with
//    no result. cmd 1 runs from start_node over csr num_nodes nodes (clamped to 2..16).
//  - rsp_ channel: one transaction per node in node order; rsp_last on the final one.
//  - csr_: write num_nodes while the block is idle.
// Operation:
//  - Node state lives in a ring of 16 cells rotating one step a cycle unless a
//    stall on rsp_ holds it. Each full rotation passes every node past the head
//    cell, which takes the registered weight store entry at (row, node) and relaxes.
//  - A run does one init rotation, then per selected node one scan rotation
//    (serial minimum search at the tail) and one relax rotation, then a last scan
//    rotation, then emits; a scan that selects no node ends the selections early.
//  - Emit rotates the ring and offers each node in use; a stall on rsp_ holds
//    the ring, so no transaction is lost.
//  - req_stall is high while a run is in progress.
//  - Reset: weight store cleared with valid bits, num_nodes back to 5.
module shortest_path_dense_graph_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [3:0]                   req_row_node,
   input  logic [3:0]                   req_col_node,
   input  logic [13:0]                  req_edge_weight,
   input  logic [3:0]                   req_start_node,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [3:0]                   rsp_node,
   output logic [17:0]                  rsp_distance,
   output logic [3:0]                   rsp_predecessor,
   output logic                         rsp_last,
   input  logic                         csr_write,
   input  logic [4:0]                   csr_data
);
   import spdg_pkg::*;
   localparam int Cells = MaxNodes * MaxNodes;

   state_type state_ff, state_in;
   logic [4:0]       num_nodes_ff;
   logic [WeightW-1:0] wmem [Cells];
   logic [Cells-1:0] wvalid_ff;
   logic [NodeW-1:0] step_ff, step_in;       // position in rotation
   logic [CntW-1:0]  iter_ff, iter_in;       // selections done
   logic [CntW-1:0]  n_ff;
   logic [NodeW-1:0] start_ff, sel_ff, start_in, sel_in;
   logic [DistW-1:0] best_ff;
   logic             found_ff;
   logic [NodeW-1:0] rd_row;
   logic [WeightW-1:0] weight_ff;
   logic [NodeW-1:0] tail_id, tail_pred;
   logic [DistW-1:0] tail_dist;
   logic             tail_vis, seed, shift, accept, emit_ok, scan_hit;
   logic [CntW-1:0]  n_clamp;
   cell_ctrl_type    ctrl;

   assign accept = req_valid && !req_stall;
   assign n_clamp = (num_nodes_ff < 5'd2) ? CntW'(2) :
                    (num_nodes_ff > 5'(MaxNodes)) ? CntW'(MaxNodes) : CntW'(num_nodes_ff);
   assign start_in = (CntW'(req_start_node) >= n_clamp) ?
                     NodeW'(n_clamp - 1'b1) : req_start_node;

   always_ff @(posedge clock) begin
      if (reset) num_nodes_ff <= 5'd5;
      else if (csr_write) num_nodes_ff <= csr_data;
   end

   // Weight store with a registered read. The head node of the next cycle is
   // always step_in (the ring's tail id follows the step count), so fetch its entry
   // ahead through the read register: the start row for init, the newly selected row for relax.
   assign rd_row = (state_ff == ST_IDLE) ? start_in :
                   (state_ff == ST_INIT) ? start_ff : sel_in;
   always_ff @(posedge clock) begin
      if (accept && req_cmd == CmdWrite)
         wmem[{req_row_node, req_col_node}] <= req_edge_weight;
      weight_ff <= wvalid_ff[{rd_row, step_in}] ? wmem[{rd_row, step_in}] : '0;
      if (reset) wvalid_ff <= '0;
      else if (accept && req_cmd == CmdWrite)
         wvalid_ff[{req_row_node, req_col_node}] <= 1'b1;
   end

   // sequencer
   assign emit_ok = (CntW'(tail_id) < n_ff);
   assign scan_hit = (state_ff == ST_SCAN) && emit_ok && !tail_vis && tail_dist < best_ff;
   assign sel_in = scan_hit ? tail_id : sel_ff;
   always_comb begin
      state_in = state_ff; step_in = step_ff; iter_in = iter_ff;
      unique case (state_ff)
         ST_IDLE: if (accept && req_cmd == CmdRun) begin
            state_in = ST_INIT; step_in = '0;
         end
         ST_INIT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == NodeW'(MaxNodes-1)) begin
               state_in = ST_SCAN; iter_in = CntW'(1);
            end
         end
         ST_SCAN: begin
            step_in = step_ff + 1'b1;
            if (step_ff == NodeW'(MaxNodes-1)) begin
               if (iter_ff + 1'b1 >= n_ff) state_in = ST_EMIT;
               else if (!found_ff && !(scan_hit)) state_in = ST_EMIT;
               else state_in = ST_RELAX;
            end
         end
         ST_RELAX: begin
            step_in = step_ff + 1'b1;
            if (step_ff == NodeW'(MaxNodes-1)) begin
               state_in = ST_SCAN; iter_in = iter_ff + 1'b1;
            end
         end
         ST_EMIT: if (!(rsp_valid && rsp_stall)) begin
            step_in = step_ff + 1'b1;
            if (emit_ok && CntW'(tail_id) == n_ff - 1'b1) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; step_ff <= '0; iter_ff <= '0;
      end else begin
         state_ff <= state_in; step_ff <= step_in; iter_ff <= iter_in;
      end
      if (state_ff == ST_IDLE && accept && req_cmd == CmdRun) begin
         n_ff <= n_clamp;
         start_ff <= start_in;
      end
      sel_ff <= sel_in;
      // hold best through the relax rotation; clear it on entry to a scan
      if (scan_hit) begin
         best_ff <= tail_dist; found_ff <= 1'b1;
      end else if (state_in == ST_SCAN && state_ff != ST_SCAN) begin
         best_ff <= InfDist; found_ff <= 1'b0;
      end
   end

   assign seed  = (state_ff == ST_INIT);
   assign shift = (state_ff == ST_INIT) || (state_ff == ST_SCAN) || (state_ff == ST_RELAX) ||
                  (state_ff == ST_EMIT && !(rsp_valid && rsp_stall));
   always_comb begin
      ctrl.init  = (state_ff == ST_INIT);
      ctrl.relax = (state_ff == ST_RELAX);
      ctrl.shift = shift;
      ctrl.start = start_ff;
      ctrl.sel   = sel_ff;
      ctrl.best  = best_ff;
   end

   spdg_chain u_chain (
      .clock, .reset, .ctrl, .weight(weight_ff), .seed, .seed_id(step_ff),
      .tail_id, .tail_dist, .tail_pred, .tail_vis
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT) && emit_ok;
   assign rsp_node = tail_id;
   assign rsp_distance = tail_dist;
   assign rsp_predecessor = tail_pred;
   assign rsp_last = (CntW'(tail_id) == n_ff - 1'b1);
endmodule

// ===== bench/testbench.sv =====
// Testbench for the dense-graph shortest path block: queued driver, scoreboard monitor.
`timescale 1ns / 100ps

module testbench;
   import spdg_pkg::*;

   typedef struct {
      logic        cmd;
      logic [3:0]  row;
      logic [3:0]  col;
      logic [13:0] weight;
      logic [3:0]  start;
   } graph_req_type;

   typedef struct {
      logic [3:0]  node;
      logic [17:0] distance;
      logic [3:0]  pred;
      logic        last;
   } node_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_cmd = CmdWrite;
   logic [3:0]  req_row_node = '0;
   logic [3:0]  req_col_node = '0;
   logic [13:0] req_edge_weight = '0;
   logic [3:0]  req_start_node = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_node;
   logic [17:0] rsp_distance;
   logic [3:0]  rsp_predecessor;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic [4:0]  csr_data = '0;

   graph_req_type   pending_reqs[$];
   node_result_type expected_nodes[$];

   // local copy of the block state
   logic [13:0] edge_store[MaxNodes][MaxNodes];
   logic [4:0]  node_count_reg;

   int  errors = 0;
   int  req_accepts = 0;      // bumped at each accepted input transaction
   int  req_taken = 0;        // driver's view of that count
   int  rsp_accepts = 0;
   int  rsp_seen = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  no_idle = 0;          // set by the sequence to run a phase back to back
   bit  hold_req = 0;
   bit  hold_done = 0;
   int  hold_cnt = 0;

   shortest_path_dense_graph_top uut (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Compute one run and queue every node's distance and predecessor.
   task automatic predict_paths(input logic [3:0] start_in);
      int unsigned n, s, best, next, cand;
      int unsigned node_dist[MaxNodes];
      int unsigned pred[MaxNodes];
      bit          seen[MaxNodes];
      bit          found;
      node_result_type r;
      n = node_count_reg;
      if (n < 2) n = 2;
      if (n > MaxNodes) n = MaxNodes;
      s = start_in;
      if (s >= n) s = n - 1;
      for (int i = 0; i < n; i++) begin
         node_dist[i] = (edge_store[s][i] == 0) ? 9999 : edge_store[s][i];
         pred[i] = s;
         seen[i] = 0;
      end
      node_dist[s] = 0;
      seen[s] = 1;
      for (int k = 1; k + 1 < n; k++) begin
         best = 9999;
         next = 0;
         found = 0;
         // strict compare keeps the lowest index on ties
         for (int i = 0; i < n; i++) begin
            if (!seen[i] && node_dist[i] < best) begin
               best = node_dist[i];
               next = i;
               found = 1;
            end
         end
         if (!found) break;
         seen[next] = 1;
         for (int i = 0; i < n; i++) begin
            if (!seen[i] && edge_store[next][i] != 0) begin
               cand = best + edge_store[next][i];
               if (cand > 262143) cand = 262143;
               if (cand < node_dist[i]) begin
                  node_dist[i] = cand;
                  pred[i] = next;
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         r.node = 4'(i);
         r.distance = 18'((node_dist[i] > 262143) ? 262143 : node_dist[i]);
         r.pred = 4'(pred[i]);
         r.last = (i + 1 == n);
         expected_nodes.push_back(r);
      end
   endtask

   // Model side: track csr writes and every accepted input transaction.
   always @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MaxNodes; r++)
            for (int c = 0; c < MaxNodes; c++)
               edge_store[r][c] = '0;
         node_count_reg = 5'd5;
      end else begin
         if (csr_write) node_count_reg = csr_data;
         if (req_valid && !req_stall) begin
            if (req_cmd == CmdWrite)
               edge_store[req_row_node][req_col_node] = req_edge_weight;
            else
               predict_paths(req_start_node);
            req_accepts++;
         end
      end
   end

   // Driver: change inputs on the falling edge, one assignment per signal.
   always @(negedge clock) begin
      graph_req_type nx;
      bit offering;
      if (!reset) begin
         offering = req_valid;
         if (req_valid && req_accepts != req_taken) begin
            req_taken <= req_accepts;
            offering = 0;
            send_gap = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nx = pending_reqs.pop_front();
               req_cmd         <= nx.cmd;
               req_row_node    <= nx.row;
               req_col_node    <= nx.col;
               req_edge_weight <= nx.weight;
               req_start_node  <= nx.start;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      node_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_accepts++;
         if (expected_nodes.size() == 0) begin
            $display("%0t: unexpected result node=%0d dist=%0d pred=%0d last=%0d",
                     $time, rsp_node, rsp_distance, rsp_predecessor, rsp_last);
            errors++;
         end else begin
            e = expected_nodes.pop_front();
            if (rsp_node !== e.node) begin
               $display("%0t: node expected %0d actual %0d", $time, e.node, rsp_node);
               errors++;
            end
            if (rsp_distance !== e.distance) begin
               $display("%0t: distance of node %0d expected %0d actual %0d",
                        $time, e.node, e.distance, rsp_distance);
               errors++;
            end
            if (rsp_predecessor !== e.pred) begin
               $display("%0t: predecessor of node %0d expected %0d actual %0d",
                        $time, e.node, e.pred, rsp_predecessor);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last of node %0d expected %0d actual %0d",
                        $time, e.node, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // Receiver: random stall per transaction, plus one long hold-off on request.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_accepts != rsp_seen) begin
            rsp_seen <= rsp_accepts;
            recv_gap = no_idle ? 0 : $urandom_range(0, 8);
         end
         if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt = 700;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_req(input logic cmd, input int row, input int col,
                           input int weight, input int start);
      graph_req_type t;
      t.cmd = cmd;
      t.row = 4'(row);
      t.col = 4'(col);
      t.weight = 14'(weight);
      t.start = 4'(start);
      pending_reqs.push_back(t);
   endtask

   // Drain all queued work, then allow a full run's latency before touching csr.
   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_valid && expected_nodes.size() == 0);
      repeat (600) @(posedge clock);
   endtask

   task automatic set_node_count(input logic [4:0] v);
      @(negedge clock);
      csr_data  <= v;
      csr_write <= 1'b1;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // Random phase: mostly edge bursts followed by a run, some lone noise items.
   task automatic random_phase(input int n, input int items);
      int cnt, lim, bursts;
      cnt = 0;
      lim = (n < 2) ? 2 : (n > MaxNodes ? MaxNodes : n);
      while (cnt < items) begin
         if ($urandom_range(0, 7) == 0) begin
            push_req(1'($urandom_range(0, 1)), $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 16383), $urandom_range(0, 15));
            cnt++;
         end else begin
            bursts = $urandom_range(1, 6);
            for (int b = 0; b < bursts; b++) begin
               push_req(CmdWrite, $urandom_range(0, lim - 1), $urandom_range(0, lim - 1),
                        ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383)
                                                    : $urandom_range(0, 60),
                        $urandom_range(0, 15));
            end
            push_req(CmdRun, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, 16383), $urandom_range(0, lim));
            cnt += bursts + 1;
         end
      end
   endtask

   initial begin
      logic [4:0] counts[5];
      counts = '{5'd2, 5'd16, 5'd0, 5'd31, 5'd9};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty graph, extreme weights, clamped start, ties, unreachable rest
      set_node_count(5'd5);
      push_req(CmdRun, 0, 0, 0, 0);
      push_req(CmdWrite, 0, 1, 4, 15);
      push_req(CmdWrite, 0, 2, 4, 0);
      push_req(CmdWrite, 1, 3, 1, 0);
      push_req(CmdWrite, 2, 3, 1, 0);
      push_req(CmdRun, 15, 15, 16383, 0);
      push_req(CmdWrite, 3, 4, 16383, 0);
      push_req(CmdWrite, 4, 0, 9998, 0);
      push_req(CmdWrite, 4, 1, 9999, 0);
      push_req(CmdRun, 0, 0, 0, 4);
      push_req(CmdRun, 0, 0, 0, 15);
      push_req(CmdWrite, 15, 15, 9998, 0);
      push_req(CmdWrite, 15, 0, 16383, 0);
      push_req(CmdWrite, 0, 1, 0, 0);
      push_req(CmdRun, 0, 0, 0, 3);
      push_req(CmdRun, 0, 0, 0, 0);
      wait_idle();

      // keep the receiver stalled while runs pile up behind it
      hold_req = 1;
      random_phase(5, 12);
      wait_idle();

      foreach (counts[i]) begin
         set_node_count(counts[i]);
         no_idle = (i == 1);
         if (i == 1) begin
            // extremes at full size: a long chain of maximum-weight edges
            for (int k = 0; k < 15; k++) push_req(CmdWrite, k, k + 1, 16383, 0);
            push_req(CmdRun, 0, 0, 0, 0);
         end
         random_phase(counts[i], 12);
         wait_idle();
      end

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== files.f =====
hdl/spdg_pkg.sv
hdl/spdg_cell.sv
hdl/spdg_chain.sv
hdl/shortest_path_dense_graph_top.sv
bench/testbench.sv
